// File: rtl/tilemap_scroll_renderer_macros.svh
// ----------------------------------------------------------------------------
// Tile map scroll renderer assertion macros
// Shared macros for the concurrent assertions of the renderer modules.
// ----------------------------------------------------------------------------
`ifndef TILEMAP_SCROLL_RENDERER_MACROS_SVH
`define TILEMAP_SCROLL_RENDERER_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define TSR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Usual form inside a module with clk_i and rst_ni.
`define TSR_ASSERT(lbl, prop, msg) \
  `TSR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// Tile map scroll renderer package
// Constants, payload types and controller interface types of the renderer.
// ----------------------------------------------------------------------------
package tsr_pkg;

  // Tile geometry in pixels. Both must be powers of two.
  localparam int unsigned TILE_W      = 32;
  localparam int unsigned TILE_H      = 32;
  localparam int unsigned TILE_W_LOG2 = $clog2(TILE_W);
  localparam int unsigned TILE_H_LOG2 = $clog2(TILE_H);

  // Map store organization.
  localparam int unsigned LAYER_DEPTH = 8192;
  localparam int unsigned LAYER_COUNT = 4;
  localparam int unsigned STORE_DEPTH = LAYER_DEPTH * LAYER_COUNT;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned LAYER_W    = 2;
  localparam int unsigned MAP_ADDR_W = 13;
  localparam int unsigned TILE_ID_W  = 12;
  localparam int unsigned POINT_W    = 16;
  localparam int unsigned CELL_W     = 12;
  localparam int unsigned SRC_X_W    = 13;
  localparam int unsigned SRC_Y_W    = 17;
  localparam int unsigned SCREEN_W   = 12;
  localparam int unsigned CAM_POS_W  = 16;
  localparam int unsigned MAP_DIM_W  = 8;
  localparam int unsigned VIEW_W     = 7;
  localparam int unsigned SHEET_W    = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [MAP_DIM_W-1:0] MAP_WIDTH_RST   = 8'd80;
  localparam logic [MAP_DIM_W-1:0] MAP_HEIGHT_RST  = 8'd60;
  localparam logic [VIEW_W-1:0]    VIEW_WIDTH_RST  = 7'd21;
  localparam logic [VIEW_W-1:0]    VIEW_HEIGHT_RST = 7'd16;
  localparam logic [SHEET_W-1:0]   SHEET_COLS_RST  = 8'd8;

  // Shared divider: 12-bit dividend, 8-bit divisor, two quotient bits a cycle.
  localparam int unsigned DIVIDEND_W        = 12;
  localparam int unsigned DIVISOR_W         = 8;
  localparam int unsigned DIV_BITS_PER_STEP = 2;
  localparam int unsigned DIV_STEPS         = DIVIDEND_W / DIV_BITS_PER_STEP;
  localparam int unsigned DIV_CNT_W         = $clog2(DIV_STEPS);

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_CAMERA = 2'd1,
    ACT_RENDER = 2'd2,
    ACT_NONE   = 2'd3
  } tsr_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_HEIGHT  = 3'd1,
    REG_VIEW_WIDTH  = 3'd2,
    REG_VIEW_HEIGHT = 3'd3,
    REG_SHEET_COLS  = 3'd4
  } tsr_reg_e;

  localparam logic [LAYER_W-1:0] LAYER_BACKGROUND = 2'd0;
  localparam logic [LAYER_W-1:0] LAYER_OVERLAY    = 2'd3;

  typedef struct packed {
    tsr_action_e                action;
    logic [LAYER_W-1:0]         layer;
    logic [MAP_ADDR_W-1:0]      map_address;
    logic [TILE_ID_W-1:0]       tile_value;
    logic signed [POINT_W-1:0]  point_x;
    logic signed [POINT_W-1:0]  point_y;
    logic [CELL_W-1:0]          view_cell;
  } tsr_in_t;

  typedef struct packed {
    logic                        draw;
    logic                        blend_on;
    logic                        fill_rect;
    logic [SRC_X_W-1:0]          source_x;
    logic [SRC_Y_W-1:0]          source_y;
    logic signed [SCREEN_W-1:0]  screen_x;
    logic signed [SCREEN_W-1:0]  screen_y;
    logic                        out_of_map;
    logic signed [CAM_POS_W-1:0] camera_x;
    logic signed [CAM_POS_W-1:0] camera_y;
  } tsr_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic write_tile;
    logic move_camera;
    logic start_cell_div;
    logic capture_cell;
    logic index_product;
    logic index_sum;
    logic check_index;
    logic eval_tile;
    logic start_tile_div;
    logic capture_source;
    logic finish;
  } tsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    tsr_action_e action;
    logic        in_view;
    logic        div_done;
    logic        index_ok;
    logic        tile_nonzero;
    logic        fill_layer;
  } tsr_status_t;

endpackage

// File: rtl/tsr_divider.sv
// ----------------------------------------------------------------------------
// Tile map scroll renderer divider
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tsr_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tsr_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [tsr_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                             done_o,
  output logic [tsr_pkg::DIVIDEND_W-1:0]   quotient_o,
  output logic [tsr_pkg::DIVISOR_W-1:0]    remainder_o
);
  import tsr_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q;
  logic                  last_step;

  assign last_step = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  // The remainder always stays below the divisor, so it fits the divisor width.
  always_comb begin : step_logic
    logic [DIVISOR_W:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      trial = {rem_d, quo_d[DIVIDEND_W-1]};
      quo_d = {quo_d[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: rtl/tsr_datapath.sv
// ----------------------------------------------------------------------------
// Tile map scroll renderer datapath
// Configuration and camera registers, map store, index arithmetic and the
// result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module tsr_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tsr_pkg::tsr_in_t                 in_data_i,
  input  logic                             cfg_we_i,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tsr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  tsr_pkg::tsr_cmd_t                cmd_i,
  output tsr_pkg::tsr_status_t             status_o,
  output tsr_pkg::tsr_out_t                out_data_o
);
  import tsr_pkg::*;

  localparam int unsigned CAM_W = 20;  // camera clamp arithmetic
  localparam int unsigned MAG_W = 17;  // camera magnitude and tile split
  localparam int unsigned IDX_W = 24;  // signed map index
  localparam int unsigned SCR_W = 20;  // screen position before wrap

  function automatic logic signed [CAM_W-1:0] lock_axis(
    input logic signed [POINT_W-1:0] point,
    input logic [VIEW_W-1:0]         view_tiles,
    input logic [MAP_DIM_W-1:0]      map_tiles,
    input int unsigned               shift
  );
    logic signed [CAM_W-1:0] view_px;
    logic signed [CAM_W-1:0] hi;
    logic signed [CAM_W-1:0] c;
    view_px = $signed(CAM_W'(view_tiles) << shift);
    hi      = $signed(CAM_W'(map_tiles) << shift) - view_px;
    c       = CAM_W'(point) - (view_px >>> 1);
    if (c < 0) begin
      lock_axis = '0;
    end else if (c > hi) begin
      lock_axis = hi;
    end else begin
      lock_axis = c;
    end
  endfunction

  // Quotient and remainder by a tile size, both truncating toward zero.
  function automatic logic signed [MAG_W-1:0] tile_of(
    input logic signed [CAM_POS_W-1:0] pos,
    input int unsigned                 shift
  );
    logic signed [MAG_W-1:0] ext;
    logic [MAG_W-1:0]        mag;
    ext     = MAG_W'(pos);
    mag     = ext[MAG_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
    tile_of = ext[MAG_W-1] ? -$signed(mag >> shift) : $signed(mag >> shift);
  endfunction

  function automatic logic signed [MAG_W-1:0] offset_of(
    input logic signed [CAM_POS_W-1:0] pos,
    input int unsigned                 shift
  );
    logic signed [MAG_W-1:0] ext;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        rem;
    ext       = MAG_W'(pos);
    mag       = ext[MAG_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
    rem       = mag & MAG_W'((1 << shift) - 1);
    offset_of = ext[MAG_W-1] ? -$signed(rem) : $signed(rem);
  endfunction

  // Configuration and camera.
  logic [MAP_DIM_W-1:0]        mw_q, mh_q;
  logic [VIEW_W-1:0]           vw_q, vh_q;
  logic [SHEET_W-1:0]          sc_q;
  logic signed [CAM_POS_W-1:0] cam_x_q, cam_y_q;

  // Item and work registers.
  tsr_in_t                     item_q;
  logic [DIVISOR_W-1:0]        col_q;
  logic [DIVIDEND_W-1:0]       row_q;
  logic signed [IDX_W-1:0]     prod_q, colmx_q, idx_q;
  logic [TILE_ID_W-1:0]        rd_data_q;
  logic                        draw_q, oom_q;
  logic [SRC_X_W-1:0]          sx_q;
  logic [SRC_Y_W-1:0]          sy_q;
  logic signed [SCREEN_W-1:0]  scx_q, scy_q;
  tsr_out_t                    res_q;

  logic [TILE_ID_W-1:0]        tile_mem [STORE_DEPTH];

  logic [VIEW_W-1:0]           vw_eff;
  logic [SHEET_W-1:0]          sc_eff;
  logic [2*VIEW_W-1:0]         view_cells;
  logic                        in_view;
  logic signed [MAG_W-1:0]     mx, my, ox, oy;
  logic                        layer_ok;
  logic                        index_ok;
  logic                        is_render;
  logic                        is_fill;
  logic [STORE_AW-1:0]         wr_addr, rd_addr;
  logic                        wr_en;
  logic                        div_start, div_done;
  logic [DIVIDEND_W-1:0]       div_dividend, div_quotient;
  logic [DIVISOR_W-1:0]        div_divisor, div_remainder;

  assign vw_eff     = (vw_q == '0) ? VIEW_W'(1) : vw_q;
  assign sc_eff     = (sc_q == '0) ? SHEET_W'(1) : sc_q;
  assign view_cells = (2*VIEW_W)'(vw_eff) * (2*VIEW_W)'(vh_q);
  assign in_view    = (2*VIEW_W)'(item_q.view_cell) < view_cells;

  assign mx = tile_of(cam_x_q, TILE_W_LOG2);
  assign my = tile_of(cam_y_q, TILE_H_LOG2);
  assign ox = offset_of(cam_x_q, TILE_W_LOG2);
  assign oy = offset_of(cam_y_q, TILE_H_LOG2);

  assign layer_ok  = 32'(item_q.layer) < LAYER_COUNT;
  assign index_ok  = !idx_q[IDX_W-1] && (idx_q < $signed(IDX_W'(LAYER_DEPTH))) && layer_ok;
  assign is_render = (item_q.action == ACT_RENDER);
  assign is_fill   = (item_q.layer == LAYER_OVERLAY);

  assign wr_en   = cmd_i.write_tile && layer_ok && (32'(item_q.map_address) < LAYER_DEPTH);
  assign wr_addr = STORE_AW'(32'(item_q.layer) * LAYER_DEPTH + 32'(item_q.map_address));
  assign rd_addr = STORE_AW'(32'(item_q.layer) * LAYER_DEPTH + 32'($unsigned(idx_q)));

  // The divider serves the view cell split and the tile sheet split in turn.
  assign div_start    = cmd_i.start_cell_div || cmd_i.start_tile_div;
  assign div_dividend = cmd_i.start_cell_div ? DIVIDEND_W'(item_q.view_cell)
                                             : DIVIDEND_W'(rd_data_q - TILE_ID_W'(1));
  assign div_divisor  = cmd_i.start_cell_div ? DIVISOR_W'(vw_eff) : DIVISOR_W'(sc_eff);

  tsr_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mw_q    <= MAP_WIDTH_RST;
      mh_q    <= MAP_HEIGHT_RST;
      vw_q    <= VIEW_WIDTH_RST;
      vh_q    <= VIEW_HEIGHT_RST;
      sc_q    <= SHEET_COLS_RST;
      cam_x_q <= '0;
      cam_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MAP_WIDTH:   mw_q <= cfg_data_i[MAP_DIM_W-1:0];
          REG_MAP_HEIGHT:  mh_q <= cfg_data_i[MAP_DIM_W-1:0];
          REG_VIEW_WIDTH:  vw_q <= cfg_data_i[VIEW_W-1:0];
          REG_VIEW_HEIGHT: vh_q <= cfg_data_i[VIEW_W-1:0];
          REG_SHEET_COLS:  sc_q <= cfg_data_i[SHEET_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.move_camera) begin
        cam_x_q <= CAM_POS_W'(lock_axis(item_q.point_x, vw_q, mw_q, TILE_W_LOG2));
        cam_y_q <= CAM_POS_W'(lock_axis(item_q.point_y, vh_q, mh_q, TILE_H_LOG2));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tile_mem[wr_addr] <= item_q.tile_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check_index) begin
      rd_data_q <= tile_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      draw_q <= 1'b0;
      oom_q  <= 1'b0;
      sx_q   <= '0;
      sy_q   <= '0;
      scx_q  <= '0;
      scy_q  <= '0;
    end
    if (cmd_i.capture_cell) begin
      col_q <= div_remainder;
      row_q <= div_quotient;
    end
    if (cmd_i.index_product) begin
      prod_q  <= ($signed(IDX_W'(row_q)) + IDX_W'(my)) * $signed(IDX_W'(mw_q));
      colmx_q <= $signed(IDX_W'(col_q)) + IDX_W'(mx);
    end
    if (cmd_i.index_sum) begin
      idx_q <= prod_q + colmx_q;
    end
    if (cmd_i.check_index) begin
      oom_q <= !index_ok;
    end
    if (cmd_i.eval_tile && (rd_data_q != '0)) begin
      draw_q <= 1'b1;
      scx_q  <= SCREEN_W'((SCR_W'(col_q) << TILE_W_LOG2) - SCR_W'(ox));
      scy_q  <= SCREEN_W'((SCR_W'(row_q) << TILE_H_LOG2) - SCR_W'(oy));
    end
    if (cmd_i.capture_source) begin
      sx_q <= SRC_X_W'(32'(div_remainder) << TILE_W_LOG2);
      sy_q <= SRC_Y_W'(32'(div_quotient) << TILE_H_LOG2);
    end
    if (cmd_i.finish) begin
      res_q.draw       <= draw_q;
      res_q.blend_on   <= is_render && (item_q.layer != LAYER_BACKGROUND);
      res_q.fill_rect  <= is_render && is_fill;
      res_q.source_x   <= sx_q;
      res_q.source_y   <= sy_q;
      res_q.screen_x   <= scx_q;
      res_q.screen_y   <= scy_q;
      res_q.out_of_map <= oom_q;
      res_q.camera_x   <= cam_x_q;
      res_q.camera_y   <= cam_y_q;
    end
  end

  assign status_o.action       = item_q.action;
  assign status_o.in_view      = in_view;
  assign status_o.div_done     = div_done;
  assign status_o.index_ok     = index_ok;
  assign status_o.tile_nonzero = (rd_data_q != '0);
  assign status_o.fill_layer   = is_fill;

  assign out_data_o = res_q;

endmodule

// File: rtl/tsr_controller.sv
// ----------------------------------------------------------------------------
// Tile map scroll renderer controller
// Sequences each item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`include "tilemap_scroll_renderer_macros.svh"

module tsr_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  tsr_pkg::tsr_status_t  status_i,
  output tsr_pkg::tsr_cmd_t     cmd_o
);
  import tsr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DISPATCH  = 9'b000000010,
    S_DIV_CELL  = 9'b000000100,
    S_INDEX_MUL = 9'b000001000,
    S_INDEX_SUM = 9'b000010000,
    S_CHECK     = 9'b000100000,
    S_READ      = 9'b001000000,
    S_DIV_TILE  = 9'b010000000,
    S_FINISH    = 9'b100000000
  } tsr_state_e;

  tsr_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_take;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_FINISH;
        case (status_i.action)
          ACT_WRITE:  cmd_o.write_tile  = 1'b1;
          ACT_CAMERA: cmd_o.move_camera = 1'b1;
          ACT_RENDER: begin
            if (status_i.in_view) begin
              cmd_o.start_cell_div = 1'b1;
              state_d              = S_DIV_CELL;
            end
          end
          default: ;
        endcase
      end
      S_DIV_CELL: begin
        if (status_i.div_done) begin
          cmd_o.capture_cell = 1'b1;
          state_d            = S_INDEX_MUL;
        end
      end
      S_INDEX_MUL: begin
        cmd_o.index_product = 1'b1;
        state_d             = S_INDEX_SUM;
      end
      S_INDEX_SUM: begin
        cmd_o.index_sum = 1'b1;
        state_d         = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check_index = 1'b1;
        state_d           = status_i.index_ok ? S_READ : S_FINISH;
      end
      S_READ: begin
        cmd_o.eval_tile = 1'b1;
        if (status_i.tile_nonzero && !status_i.fill_layer) begin
          cmd_o.start_tile_div = 1'b1;
          state_d              = S_DIV_TILE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_DIV_TILE: begin
        if (status_i.div_done) begin
          cmd_o.capture_source = 1'b1;
          state_d              = S_FINISH;
        end
      end
      S_FINISH: begin
        // The result register is loaded once it is empty or being emptied.
        if (!out_valid_q || out_take) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `TSR_ASSERT(a_accept_dispatch, (in_valid_i && !in_stall_o) |=> (state_q == S_DISPATCH), "accepted transaction not dispatched")
  `TSR_ASSERT(a_result_held, (out_valid_q && out_stall_i) |=> out_valid_q, "stalled result dropped")
  `TSR_ASSERT(a_finish_room, cmd_o.finish |-> (!out_valid_q || !out_stall_i), "result register overwritten")
  `TSR_ASSERT(a_div_wait, status_i.div_done |-> (state_q == S_DIV_CELL || state_q == S_DIV_TILE), "divider finished outside a wait state")

endmodule

// File: rtl/tilemap_scroll_renderer.sv
// ----------------------------------------------------------------------------
// Tile map scroll renderer
// Four-layer tile map store with a clamped camera and per-cell render lookup.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns exactly one result
// transaction for each. A write transaction stores a tile id, a camera
// transaction centres the camera on a world point and clamps it to the map,
// and a render transaction looks up the tile under one view cell and reports
// its tile sheet origin and screen position. A write or camera transaction
// is dispatched and then has its result loaded, after which the block
// returns to idle and can take the next transaction. A render transaction
// that draws a tile from the sheet goes through dispatch, the view cell
// split, the index multiply, the index add, the registered map store read
// with the index check, the tile check, the tile sheet split and the result
// load; renders that stop early skip the later steps. Both splits run on
// the shared divider, which produces two quotient bits per cycle and
// reports completion through a registered done flag. The result sits in an
// output register, so the next transaction is accepted while a finished
// result still waits to be taken. Configuration registers are written
// through their own port, which is always ready, and must only be written
// while the block is idle. The map store is not cleared at reset: a render
// of an entry that was never written returns an arbitrary tile id.
module tilemap_scroll_renderer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Item input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tsr_pkg::tsr_in_t                 in_data_i,
  // Result output channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tsr_pkg::tsr_out_t                out_data_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tsr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tsr_pkg::*;

  tsr_cmd_t    cmd;
  tsr_status_t status;
  logic        cfg_we;

  // The port never pushes back, so every offered register write is taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // The controller owns both handshakes and walks each transaction through
  // its steps; it sees the datapath only through the status struct.
  tsr_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, the map store, the shared divider and
  // the result register.
  tsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile map scroll renderer testbench
// Drives write, camera, render and idle transactions into the renderer under
// random flow control on both channels. Every result is checked, most of them
// against a tile map predictor kept inside the bench.
// ----------------------------------------------------------------------------
// The run has two parts. A short directed table comes first at the reset
// settings. It covers the camera clamp at both ends, the largest tile id,
// the overlay layer, empty tiles, cells outside the view and negative screen
// offsets. Rows whose result is obvious carry a typed-in expectation; the
// other rows use the predictor. After that, several register settings are
// loaded in turn, each followed by random traffic: the largest map and view,
// the smallest, a view taller than the map with a zero view width and zero
// sheet columns, a mid-size setting, a random one and the reset values again.
// The map store is not cleared at reset, so a render is only sent once the
// entry under its cell holds a known tile id. When the entry is still
// unknown, a write to that entry goes out first.
module tb_top;
  import tsr_pkg::*;

  // Signed copies of the tile size, so that divisions of a negative camera
  // position truncate toward zero as the block does.
  localparam int TW = TILE_W;
  localparam int TH = TILE_H;
  localparam int MAP_DEPTH = LAYER_DEPTH;

  // Where a view cell lands, relative to the view and to the layer store.
  localparam int CELL_OUTSIDE_VIEW = 0;
  localparam int CELL_OFF_MAP      = 1;
  localparam int CELL_ON_MAP       = 2;

  localparam int ITEMS_PER_SETTING = 160;
  localparam int SETTING_COUNT     = 6;
  localparam int HOLD_AFTER        = 300;
  localparam int HOLD_CYCLES       = 400;
  localparam int MAX_REPORTS       = 10;

  typedef struct {
    tsr_in_t  item;
    bit       fixed;
    tsr_out_t want;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall_o;
  tsr_in_t               in_data;
  logic                  out_valid_o;
  logic                  out_stall;
  tsr_out_t              out_data_o;
  logic                  cfg_valid;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: the four layers, which entries hold a known id, the
  // camera in world pixels and the register copies.
  logic [TILE_ID_W-1:0] tile_mem  [STORE_DEPTH];
  bit                   tile_seen [STORE_DEPTH];
  int cam_x = 0;
  int cam_y = 0;
  int cfg_map_w  = MAP_WIDTH_RST;
  int cfg_map_h  = MAP_HEIGHT_RST;
  int cfg_view_w = VIEW_WIDTH_RST;
  int cfg_view_h = VIEW_HEIGHT_RST;
  int cfg_sheet  = SHEET_COLS_RST;

  tsr_out_t  expected_results [$];
  stim_row_t directed_rows [$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  sent_count   = 0;
  bit  no_idle      = 1'b0;

  tilemap_scroll_renderer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The camera is centred on the point and then kept on the map. When the
  // view is larger than the map, the upper bound goes negative; it wins unless the centred point is below zero.
  function automatic int clamp_camera(int point, int view_tiles, int map_tiles, int tile);
    int view_px;
    int upper;
    int c;
    view_px = view_tiles * tile;
    upper   = map_tiles * tile - view_px;
    c       = point - view_px / 2;
    if (c < 0) return 0;
    if (c > upper) return upper;
    return c;
  endfunction

  // Splits a view cell into column and row and works out the map index
  // under it for the present camera.
  function automatic int locate_cell(input int vcell, output int col, output int row,
                                     output int idx);
    int vw;
    vw  = (cfg_view_w != 0) ? cfg_view_w : 1;
    col = 0;
    row = 0;
    idx = 0;
    if (vcell >= vw * cfg_view_h) return CELL_OUTSIDE_VIEW;
    col = vcell % vw;
    row = vcell / vw;
    idx = (row + cam_y / TH) * cfg_map_w + col + cam_x / TW;
    if (idx < 0 || idx >= MAP_DEPTH) return CELL_OFF_MAP;
    return CELL_ON_MAP;
  endfunction

  // Applies one accepted transaction to the predictor state and returns
  // the result the block must give for it.
  function automatic tsr_out_t compute_tile_result(tsr_in_t it);
    tsr_out_t    r;
    int          col;
    int          row;
    int          idx;
    int          place;
    int          scx;
    int          scy;
    int unsigned id;
    int unsigned sc;
    int unsigned sx;
    int unsigned sy;
    logic [12:0] cell_addr;
    r = '0;
    case (it.action)
      ACT_WRITE: begin
        tile_mem[{it.layer, it.map_address}]  = it.tile_value;
        tile_seen[{it.layer, it.map_address}] = 1'b1;
      end
      ACT_CAMERA: begin
        cam_x = clamp_camera($signed(it.point_x), cfg_view_w, cfg_map_w, TW);
        cam_y = clamp_camera($signed(it.point_y), cfg_view_h, cfg_map_h, TH);
      end
      ACT_RENDER: begin
        r.blend_on  = (it.layer != LAYER_BACKGROUND);
        r.fill_rect = (it.layer == LAYER_OVERLAY);
        place = locate_cell(it.view_cell, col, row, idx);
        if (place == CELL_OFF_MAP) begin
          r.out_of_map = 1'b1;
        end else if (place == CELL_ON_MAP) begin
          cell_addr = idx[12:0];
          id = tile_mem[{it.layer, cell_addr}];
          if (id != 0) begin
            r.draw = 1'b1;
            // The overlay is a filled square, so it has no sheet origin.
            if (!r.fill_rect) begin
              sc = (cfg_sheet != 0) ? cfg_sheet : 1;
              sx = TW * ((id - 1) % sc);
              sy = TH * ((id - 1) / sc);
              r.source_x = sx[SRC_X_W-1:0];
              r.source_y = sy[SRC_Y_W-1:0];
            end
            scx = col * TW - cam_x % TW;
            scy = row * TH - cam_y % TH;
            r.screen_x = scx[SCREEN_W-1:0];
            r.screen_y = scy[SCREEN_W-1:0];
          end
        end
      end
      default: ;
    endcase
    r.camera_x = cam_x[CAM_POS_W-1:0];
    r.camera_y = cam_y[CAM_POS_W-1:0];
    return r;
  endfunction

  function automatic string fmt_result(tsr_out_t r);
    return $sformatf("draw=%0d blend=%0d fill=%0d src=(%0d,%0d) scr=(%0d,%0d) oom=%0d cam=(%0d,%0d)",
                     r.draw, r.blend_on, r.fill_rect, r.source_x, r.source_y,
                     $signed(r.screen_x), $signed(r.screen_y), r.out_of_map,
                     $signed(r.camera_x), $signed(r.camera_y));
  endfunction

  function automatic tsr_in_t mk_in(tsr_action_e a, logic [1:0] layer, logic [12:0] addr,
                                    logic [11:0] value, logic [15:0] px, logic [15:0] py,
                                    logic [11:0] vcell);
    tsr_in_t it;
    it.action      = a;
    it.layer       = layer;
    it.map_address = addr;
    it.tile_value  = value;
    it.point_x     = px;
    it.point_y     = py;
    it.view_cell   = vcell;
    return it;
  endfunction

  function automatic tsr_out_t mk_out(logic draw, logic blend, logic fill, logic [12:0] sx,
                                      logic [16:0] sy, logic [11:0] scx, logic [11:0] scy,
                                      logic oom, logic [15:0] cx, logic [15:0] cy);
    tsr_out_t r;
    r.draw       = draw;
    r.blend_on   = blend;
    r.fill_rect  = fill;
    r.source_x   = sx;
    r.source_y   = sy;
    r.screen_x   = scx;
    r.screen_y   = scy;
    r.out_of_map = oom;
    r.camera_x   = cx;
    r.camera_y   = cy;
    return r;
  endfunction

  function automatic void add_row(tsr_in_t it, bit fixed, tsr_out_t want);
    stim_row_t row;
    row.item  = it;
    row.fixed = fixed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Every field gets random bits, even the ones the action does not use.
  function automatic tsr_in_t rand_item();
    tsr_in_t     it;
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    it.action      = tsr_action_e'(a[1:0]);
    it.layer       = a[3:2];
    it.map_address = a[16:4];
    it.tile_value  = a[28:17];
    it.point_x     = b[15:0];
    it.point_y     = b[31:16];
    a = $urandom;
    it.view_cell   = a[11:0];
    return it;
  endfunction

  // Empty tiles are common so that both values of the draw flag show up.
  function automatic logic [11:0] pick_tile();
    logic [31:0] v;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 25)      v = 0;
    else if (r < 30) v = 4095;
    else if (r < 35) v = 1;
    else             v = $urandom_range(1, 4095);
    return v[11:0];
  endfunction

  // Mostly points near the map, sometimes anywhere in the 16-bit range.
  function automatic logic [15:0] pick_point();
    logic [31:0] v;
    if ($urandom_range(0, 9) < 7) v = $urandom_range(0, 8800) - 200;
    else                          v = $urandom;
    return v[15:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int view_cell_count();
    int n;
    n = ((cfg_view_w != 0) ? cfg_view_w : 1) * cfg_view_h;
    return (n > 4096) ? 4096 : n;
  endfunction

  // Offers one transaction after a random gap and holds it until accepted.
  // The caller must follow with another issue or with drop_valid, so that
  // the valid line falls at the negative edge right after acceptance.
  task automatic issue(input tsr_in_t it, input bit fixed, input tsr_out_t want);
    tsr_out_t predicted;
    int       gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = compute_tile_result(it);
    expected_results.push_back(fixed ? want : predicted);
    sent_count++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Register writes stay back to back; the caller lowers the valid line.
  task automatic write_reg(input tsr_reg_e idx, input int val);
    logic [7:0] v;
    v = val[7:0];
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MAP_WIDTH:   cfg_map_w  = v;
      REG_MAP_HEIGHT:  cfg_map_h  = v;
      REG_VIEW_WIDTH:  cfg_view_w = v[6:0];
      REG_VIEW_HEIGHT: cfg_view_h = v[6:0];
      REG_SHEET_COLS:  cfg_sheet  = v;
      default: ;
    endcase
  endtask

  // Registers change only with the block idle: all results in, then a
  // pause longer than the slowest render.
  task automatic load_setting(input int mw, input int mh, input int vw, input int vh,
                              input int sc);
    drop_valid();
    wait_drained();
    repeat (25) @(posedge clk_i);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_MAP_HEIGHT, mh);
    write_reg(REG_VIEW_WIDTH, vw);
    write_reg(REG_VIEW_HEIGHT, vh);
    write_reg(REG_SHEET_COLS, sc);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // One random transaction. Writes often aim at the cells in view so that
  // renders find real tiles; a render whose entry is still unknown gets a
  // write to that entry first.
  task automatic random_item();
    tsr_in_t it;
    tsr_in_t wr;
    int      r;
    int      cell_no;
    int      col;
    int      row;
    int      idx;
    int      place;
    it = rand_item();
    r  = $urandom_range(0, 99);
    if (r < 30) begin
      it.action = ACT_WRITE;
      if ($urandom_range(0, 1)) begin
        cell_no = $urandom_range(0, view_cell_count() - 1);
        if (locate_cell(cell_no, col, row, idx) == CELL_ON_MAP) it.map_address = idx[12:0];
      end
      it.tile_value = pick_tile();
    end else if (r < 42) begin
      it.action  = ACT_CAMERA;
      it.point_x = pick_point();
      it.point_y = pick_point();
    end else if (r < 95) begin
      it.action = ACT_RENDER;
      if ($urandom_range(0, 99) < 85) begin
        cell_no = $urandom_range(0, view_cell_count() - 1);
        it.view_cell = cell_no[11:0];
      end
      place = locate_cell(it.view_cell, col, row, idx);
      if (place == CELL_ON_MAP && !tile_seen[{it.layer, idx[12:0]}]) begin
        wr             = rand_item();
        wr.action      = ACT_WRITE;
        wr.layer       = it.layer;
        wr.map_address = idx[12:0];
        wr.tile_value  = pick_tile();
        issue(wr, 1'b0, '0);
      end
    end else begin
      it.action = ACT_NONE;
    end
    issue(it, 1'b0, '0);
  endtask

  // Result side: random stalls, plus one long hold-off once a few hundred
  // results are in, so the block fills up and stalls its input.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_done;
    int r;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!no_idle) begin
          r = $urandom_range(0, 99);
          if (r < 70)      stall_left = 0;
          else if (r < 92) stall_left = $urandom_range(1, 3);
          else if (r < 99) stall_left = $urandom_range(4, 15);
          else             stall_left = $urandom_range(30, 80);
        end
      end
    end
  end

  // Each accepted result is checked field by field against the oldest
  // expected one.
  always @(posedge clk_i) begin
    tsr_out_t want;
    tsr_out_t got;
    string    bad;
    if (rst_ni && out_valid_o && !out_stall) begin
      got = out_data_o;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Result %0d arrived with nothing expected: %s", results_seen,
                   fmt_result(got));
      end else begin
        want = expected_results.pop_front();
        bad  = "";
        if (got.draw !== want.draw)             bad = {bad, " draw"};
        if (got.blend_on !== want.blend_on)     bad = {bad, " blend_on"};
        if (got.fill_rect !== want.fill_rect)   bad = {bad, " fill_rect"};
        if (got.source_x !== want.source_x)     bad = {bad, " source_x"};
        if (got.source_y !== want.source_y)     bad = {bad, " source_y"};
        if (got.screen_x !== want.screen_x)     bad = {bad, " screen_x"};
        if (got.screen_y !== want.screen_y)     bad = {bad, " screen_y"};
        if (got.out_of_map !== want.out_of_map) bad = {bad, " out_of_map"};
        if (got.camera_x !== want.camera_x)     bad = {bad, " camera_x"};
        if (got.camera_y !== want.camera_y)     bad = {bad, " camera_y"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Result %0d wrong in%s\n  expected %s\n  actual   %s", results_seen,
                     bad, fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  initial begin : limit
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int setting [SETTING_COUNT][5];
    int n;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAP_WIDTH;
    cfg_data  = '0;
    rst_ni    = 1'b0;

    // Directed rows at the reset settings: 80 x 60 map, 21 x 16 view,
    // 8 sheet columns, camera at the origin.
    add_row(mk_in(ACT_CAMERA, 0, 0, 0, 16'd0, 16'd0, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(ACT_WRITE, 0, 0, 1, 0, 0, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(ACT_RENDER, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_out(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Overlay: drawn as a fill, so no sheet origin.
    add_row(mk_in(ACT_WRITE, 3, 1, 12'hFFF, 0, 0, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(ACT_RENDER, 3, 0, 0, 0, 0, 1), 1'b1,
            mk_out(1, 1, 1, 0, 0, 32, 0, 0, 0, 0));
    // Largest tile id on a blended layer: the deepest sheet position.
    add_row(mk_in(ACT_WRITE, 1, 2, 12'hFFF, 0, 0, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(ACT_RENDER, 1, 0, 0, 0, 0, 2), 1'b1,
            mk_out(1, 1, 0, 192, 16352, 64, 0, 0, 0, 0));
    // Empty tile: nothing drawn, only the layer flags.
    add_row(mk_in(ACT_WRITE, 2, 80, 0, 0, 0, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(ACT_RENDER, 2, 0, 0, 0, 0, 21), 1'b1,
            mk_out(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // Cell past the end of the view.
    add_row(mk_in(ACT_RENDER, 2, 0, 0, 0, 0, 12'hFFF), 1'b1,
            mk_out(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(ACT_WRITE, 0, 13'h1FFF, 2, 0, 0, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Last cell of the view: row 15, column 20, map index 1220.
    add_row(mk_in(ACT_WRITE, 0, 1220, 9, 0, 0, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_in(ACT_RENDER, 0, 0, 0, 0, 0, 335), 1'b1,
            mk_out(1, 0, 0, 0, 32, 640, 480, 0, 0, 0));
    // Largest point: the camera stops at the far map corner.
    add_row(mk_in(ACT_CAMERA, 0, 0, 0, 16'h7FFF, 16'h7FFF, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 1888, 1408));
    add_row(mk_in(ACT_WRITE, 0, 3579, 100, 0, 0, 0), 1'b0, '0);
    add_row(mk_in(ACT_RENDER, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    // Smallest point: the camera stops at the origin.
    add_row(mk_in(ACT_CAMERA, 0, 0, 0, 16'h8000, 16'h8000, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Camera off the tile grid, so the screen position goes negative.
    add_row(mk_in(ACT_CAMERA, 0, 0, 0, 16'd1000, 16'd700, 0), 1'b0, '0);
    add_row(mk_in(ACT_WRITE, 2, 1060, 37, 0, 0, 0), 1'b0, '0);
    add_row(mk_in(ACT_RENDER, 2, 0, 0, 0, 0, 0), 1'b0, '0);
    // The unused action code leaves everything alone, whatever its fields.
    add_row(mk_in(ACT_NONE, 3, 13'h1FFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 12'hFFF), 1'b0, '0);
    add_row(mk_in(ACT_CAMERA, 0, 0, 0, 16'h7FFF, 16'h8000, 0), 1'b1,
            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 1888, 0));

    // Map width, map height, view width, view height, sheet columns.
    setting[0] = '{255, 255, 64, 64, 255};
    setting[1] = '{1, 1, 1, 1, 1};
    // View taller than the map, zero view width, zero columns.
    setting[2] = '{10, 8, 0, 40, 0};
    setting[3] = '{200, 150, 40, 30, 13};
    setting[4] = '{$urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 64),
                   $urandom_range(1, 64), $urandom_range(1, 255)};
    setting[5] = '{80, 60, 21, 16, 8};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

    for (int s = 0; s < SETTING_COUNT; s++) begin
      load_setting(setting[s][0], setting[s][1], setting[s][2], setting[s][3],
                   setting[s][4]);
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        // Every fifth stretch of 64 transactions runs with no idling at all.
        no_idle = ((sent_count / 64) % 5) == 4;
        random_item();
        // Halfway through each setting the sender waits for the block to drain.
        if (n == ITEMS_PER_SETTING / 2) begin
          drop_valid();
          wait_drained();
        end
      end
    end

    drop_valid();
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: tilemap_scroll_renderer.f
+incdir+rtl
rtl/tsr_pkg.sv
rtl/tsr_divider.sv
rtl/tsr_datapath.sv
rtl/tsr_controller.sv
rtl/tilemap_scroll_renderer.sv
bench/tb_top.sv
